/* sv/canonical_huffman_code_builder_top_defines.svh */
// ----------------------------------------------------------------------------
// canonical huffman code builder assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_CODE_BUILDER_TOP_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODE_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CHB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CHB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/chb_pkg.sv */
// ----------------------------------------------------------------------------
// chb_pkg
// shared codes and default sizes of the canonical huffman code builder
// ----------------------------------------------------------------------------
package chb_pkg;

	// default table sizes
	localparam int CHB_SYMBOLS      = 256;
	localparam int CHB_MAX_CODE_LEN = 32;

	// fixed field widths
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 6;
	localparam int CODE_W = 32;

	// operation carried in the input tuser
	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_BUILD = 2'd1,
		FN_QUERY = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	// status carried in the output tuser
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_OVER      = 2'd2,
		ST_NOT_BUILT = 2'd3
	} status_t;

endpackage

/* sv/canonical_huffman_code_builder_top.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_code_builder_top
// per-symbol code length table that assigns canonical huffman codes
// ----------------------------------------------------------------------------
// Usage: one input word per operation on the s_axis channel; tuser selects
// write length, build codes, query or no-op. Every word yields exactly one
// output word on m_axis: the code in tdata together with its length, and the
// status in tuser.
// Timing: a write or a no-op answers in the cycle after acceptance, so these
// run at one word per cycle while the output drains. A query passes through
// the registered read of the length and code memories and then the output
// register. A build walks the tables: it clears the counts, then runs the
// counting sweep, the first-code pass with the kraft check and the assignment
// sweep; in each sweep a symbol with a length does a read-modify-write on the
// count or next-code memory.
// Reset: every length reads as zero through per-entry valid flops, so no
// clearing pass is needed; codes are marked not built.
// Stall: the output register holds one result; while it is stalled no new
// word is accepted.
// ----------------------------------------------------------------------------
module canonical_huffman_code_builder_top
	import chb_pkg::*;
#(
	parameter int SYMBOLS      = CHB_SYMBOLS,
	parameter int MAX_CODE_LEN = CHB_MAX_CODE_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // symbol[7:0], length[13:8], zero pad
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // code[31:0], code_length[37:32], zero pad
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	localparam int SW   = $clog2(SYMBOLS);
	localparam int SCW  = $clog2(SYMBOLS + 1);
	localparam int LENS = MAX_CODE_LEN + 1;
	localparam int LW   = $clog2(MAX_CODE_LEN + 1);
	localparam int LCW  = $clog2(MAX_CODE_LEN + 2);
	localparam int CNW  = SCW;
	localparam int CW   = MAX_CODE_LEN + CNW + 1;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_QRY     = 11'b000_0000_0010,
		S_CLR     = 11'b000_0000_0100,
		S_CNT_RD  = 11'b000_0000_1000,
		S_CNT_LEN = 11'b000_0001_0000,
		S_CNT_WR  = 11'b000_0010_0000,
		S_KR_RD   = 11'b000_0100_0000,
		S_KR_CALC = 11'b000_1000_0000,
		S_AS_RD   = 11'b001_0000_0000,
		S_AS_LEN  = 11'b010_0000_0000,
		S_AS_WR   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// input decode
	func_t             in_func;
	logic [SYM_W-1:0]  in_sym;
	logic [LEN_W-1:0]  in_len;
	logic              in_sym_ok;
	logic              accept;

	assign in_func   = func_t'(s_axis_tuser);
	assign in_sym    = s_axis_tdata[7:0];
	assign in_len    = s_axis_tdata[13:8];
	assign in_sym_ok = ({1'b0, in_sym} < 9'(SYMBOLS));

	// control registers
	logic [SCW-1:0]    sym_q;
	logic [LCW-1:0]    b_q;
	logic [LW-1:0]     cur_len_q;
	logic              any_q;
	status_t           bstat_q;
	logic              done_q;
	logic              codes_valid_q;
	status_t           build_status_q;
	logic              q_sym_ok_q;
	logic [CW-1:0]     code_q;

	// memories and their read registers
	logic [LEN_W-1:0]  len_mem [SYMBOLS];
	logic              len_vld_q [SYMBOLS];
	logic [LEN_W-1:0]  len_rd_q;
	logic              len_vrd_q;
	logic [CNW-1:0]    cnt_mem [LENS];
	logic [CNW-1:0]    cnt_rd_q;
	logic [CODE_W-1:0] nc_mem [LENS];
	logic [CODE_W-1:0] nc_rd_q;
	logic [CODE_W-1:0] code_mem [SYMBOLS];
	logic [CODE_W-1:0] code_rd_q;

	// output register
	logic              m_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic [LEN_W-1:0]  out_len_q;
	status_t           out_st_q;

	assign s_axis_tready = (state_q == S_IDLE) && !done_q && (!m_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, out_len_q, out_code_q};
	assign m_axis_tuser  = out_st_q;

	// length as stored, absent when never written
	logic [LEN_W-1:0] len_eff;
	logic             len_big;
	logic             sym_last;
	logic             b_last;

	assign len_eff  = len_vrd_q ? len_rd_q : '0;
	assign len_big  = ({1'b0, len_eff} > 7'(MAX_CODE_LEN));
	assign sym_last = (sym_q == SCW'(SYMBOLS - 1));
	assign b_last   = (b_q == LCW'(MAX_CODE_LEN));

	// kraft step: running first code plus count of this length
	logic [CW-1:0] kr_sum;
	logic [CW-1:0] kr_pow;
	logic          kr_fail;

	assign kr_sum  = code_q + CW'(cnt_rd_q);
	assign kr_pow  = CW'(1) << b_q;
	assign kr_fail = (kr_sum > kr_pow);

	// memory port control
	logic              len_we;
	logic [SW-1:0]     len_raddr;
	logic              cnt_we;
	logic [LW-1:0]     cnt_waddr;
	logic [CNW-1:0]    cnt_wdata;
	logic [LW-1:0]     cnt_raddr;
	logic              nc_we;
	logic [LW-1:0]     nc_waddr;
	logic [CODE_W-1:0] nc_wdata;
	logic              code_we;

	always_comb begin
		len_we    = accept && (in_func == FN_WRITE) && in_sym_ok;
		len_raddr = (state_q == S_IDLE) ? in_sym[SW-1:0] : sym_q[SW-1:0];
		cnt_we    = 1'b0;
		cnt_waddr = b_q[LW-1:0];
		cnt_wdata = '0;
		cnt_raddr = (state_q == S_CNT_LEN) ? LW'(len_eff) : b_q[LW-1:0];
		nc_we     = 1'b0;
		nc_waddr  = b_q[LW-1:0];
		nc_wdata  = CODE_W'(code_q);
		code_we   = 1'b0;
		case (state_q)
			S_CLR: begin
				cnt_we = 1'b1;
			end
			S_CNT_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = cur_len_q;
				cnt_wdata = CNW'(cnt_rd_q + 1'b1);
			end
			S_KR_CALC: begin
				nc_we = !kr_fail;
			end
			S_AS_WR: begin
				nc_we    = 1'b1;
				nc_waddr = cur_len_q;
				nc_wdata = nc_rd_q + 1'b1;
				code_we  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// length memory
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[in_sym[SW-1:0]] <= in_len;
		end
		len_rd_q <= len_mem[len_raddr];
	end

	// per-entry written flags of the length memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOLS; i++) begin
				len_vld_q[i] <= 1'b0;
			end
		end else if (len_we) begin
			len_vld_q[in_sym[SW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		len_vrd_q <= len_vld_q[len_raddr];
	end

	// count per length memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	// next code per length memory
	always_ff @(posedge clk) begin
		if (nc_we) begin
			nc_mem[nc_waddr] <= nc_wdata;
		end
		nc_rd_q <= nc_mem[LW'(len_eff)];
	end

	// code memory
	always_ff @(posedge clk) begin
		if (code_we) begin
			code_mem[sym_q[SW-1:0]] <= nc_rd_q;
		end
		code_rd_q <= code_mem[in_sym[SW-1:0]];
	end

	// result selection
	logic              out_load;
	logic [CODE_W-1:0] out_code_n;
	logic [LEN_W-1:0]  out_len_n;
	status_t           out_st_n;

	always_comb begin
		out_load   = 1'b0;
		out_code_n = '0;
		out_len_n  = '0;
		out_st_n   = build_status_q;
		if (accept && (in_func == FN_WRITE)) begin
			out_load = 1'b1;
			out_st_n = ST_NOT_BUILT;
		end else if (accept && (in_func == FN_NOP)) begin
			out_load = 1'b1;
		end else if (state_q == S_QRY) begin
			out_load = 1'b1;
			if (codes_valid_q) begin
				out_st_n = ST_OK;
				if (q_sym_ok_q && (len_eff != '0)) begin
					out_code_n = code_rd_q;
					out_len_n  = len_eff;
				end
			end
		end else if (done_q) begin
			out_load = 1'b1;
			out_st_n = bstat_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_code_q <= out_code_n;
			out_len_q  <= out_len_n;
			out_st_q   <= out_st_n;
		end
	end

	// operation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sym_q          <= '0;
			b_q            <= '0;
			cur_len_q      <= '0;
			any_q          <= 1'b0;
			bstat_q        <= ST_NOT_BUILT;
			done_q         <= 1'b0;
			codes_valid_q  <= 1'b0;
			build_status_q <= ST_NOT_BUILT;
			q_sym_ok_q     <= 1'b0;
			code_q         <= '0;
		end else begin
			done_q <= 1'b0;
			if (done_q) begin
				codes_valid_q  <= (bstat_q == ST_OK);
				build_status_q <= bstat_q;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_func)
							FN_WRITE: begin
								codes_valid_q  <= 1'b0;
								build_status_q <= ST_NOT_BUILT;
							end
							FN_BUILD: begin
								b_q     <= '0;
								state_q <= S_CLR;
							end
							FN_QUERY: begin
								q_sym_ok_q <= in_sym_ok;
								state_q    <= S_QRY;
							end
							default: begin
							end
						endcase
					end
				end
				S_QRY: begin
					state_q <= S_IDLE;
				end
				// zero the counts of lengths 0 to max
				S_CLR: begin
					if (b_last) begin
						sym_q   <= '0;
						any_q   <= 1'b0;
						state_q <= S_CNT_RD;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				S_CNT_RD: begin
					state_q <= S_CNT_LEN;
				end
				// count sweep: check the length, fetch its count
				S_CNT_LEN: begin
					if (len_eff == '0) begin
						if (!sym_last) begin
							sym_q   <= sym_q + 1'b1;
							state_q <= S_CNT_RD;
						end else if (any_q) begin
							b_q     <= LCW'(1);
							code_q  <= '0;
							state_q <= S_KR_RD;
						end else begin
							bstat_q <= ST_EMPTY;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (len_big) begin
						bstat_q <= ST_OVER;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_len_q <= LW'(len_eff);
						state_q   <= S_CNT_WR;
					end
				end
				S_CNT_WR: begin
					any_q <= 1'b1;
					if (sym_last) begin
						b_q     <= LCW'(1);
						code_q  <= '0;
						state_q <= S_KR_RD;
					end else begin
						sym_q   <= sym_q + 1'b1;
						state_q <= S_CNT_RD;
					end
				end
				S_KR_RD: begin
					state_q <= S_KR_CALC;
				end
				// first code of each length, with the kraft check
				S_KR_CALC: begin
					if (kr_fail) begin
						bstat_q <= ST_OVER;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						code_q <= CW'(kr_sum << 1);
						if (b_last) begin
							sym_q   <= '0;
							state_q <= S_AS_RD;
						end else begin
							b_q     <= b_q + 1'b1;
							state_q <= S_KR_RD;
						end
					end
				end
				S_AS_RD: begin
					state_q <= S_AS_LEN;
				end
				// assignment sweep: fetch next code of this length
				S_AS_LEN: begin
					if (len_eff == '0) begin
						if (sym_last) begin
							bstat_q <= ST_OK;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							sym_q   <= sym_q + 1'b1;
							state_q <= S_AS_RD;
						end
					end else begin
						cur_len_q <= LW'(len_eff);
						state_q   <= S_AS_WR;
					end
				end
				S_AS_WR: begin
					if (sym_last) begin
						bstat_q <= ST_OK;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						sym_q   <= sym_q + 1'b1;
						state_q <= S_AS_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/chb_check.sv */
// ----------------------------------------------------------------------------
// chb_check
// port-level checks of the canonical huffman code builder
// ----------------------------------------------------------------------------
`include "canonical_huffman_code_builder_top_defines.svh"

module chb_check
	import chb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,   // symbol[7:0], length[13:8], zero pad
	input logic [1:0]  s_axis_tuser,   // func[1:0]
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,   // code[31:0], code_length[37:32], zero pad
	input logic [1:0]  m_axis_tuser    // status[1:0]
);

	// handshake and word terms seen on the ports
	logic        wr_take;
	logic        out_err;
	logic        out_nb;
	logic        out_stall;
	logic [41:0] out_w;

	assign wr_take   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FN_WRITE);
	assign out_err   = m_axis_tvalid && (m_axis_tuser != ST_OK);
	assign out_nb    = m_axis_tvalid && (m_axis_tuser == ST_NOT_BUILT);
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_w     = {m_axis_tuser, m_axis_tdata};

	// any non-ok status carries an all-zero word
	`CHB_ASSERT_SAME(a_err_zero, out_err, m_axis_tdata == '0, "non-ok status with nonzero word")

	// a length write answers in the next cycle with not built
	`CHB_ASSERT_NEXT(a_write_resp, wr_take, out_nb, "write not answered next cycle")

	// nothing is taken while the output word is stalled
	`CHB_ASSERT_SAME(a_stall_block, out_stall, !s_axis_tready, "input taken while stalled")

	// a stalled output word stays valid
	`CHB_ASSERT_NEXT(a_valid_hold, out_stall, m_axis_tvalid, "stalled word dropped")

	// a stalled output word holds its contents
	`CHB_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_w), "stalled word changed")

endmodule

bind canonical_huffman_code_builder_top chb_check u_chb_check (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the canonical huffman code builder
// ----------------------------------------------------------------------------
// Sends write, build, query and no-op words and predicts each answer from a
// local copy of the length and code tables. Every output word is checked in
// order against the oldest predicted answer. Stimulus starts with a directed
// list of table corner cases. Random rounds follow, each built from a
// split-tree set of lengths. Some sets are complete, some have entries
// dropped, some are oversubscribed, some hold an overlong length, and some
// are empty. The run ends with one full 256-symbol table.
// ----------------------------------------------------------------------------
module tb_top;
	import chb_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam int CALM_LO     = 300;
	localparam int CALM_HI     = 420;

	typedef struct {
		func_t              fn;
		logic [SYM_W-1:0]   sym;
		logic [LEN_W-1:0]   len;
		bit                 drain;   // hold until every answer is back
	} table_op_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [LEN_W-1:0]   clen;
		status_t            st;
	} table_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // symbol[7:0], length[13:8], zero pad
	logic [1:0]  s_axis_tuser = '0;   // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // code[31:0], code_length[37:32], zero pad
	logic [1:0]  m_axis_tuser;        // status[1:0]

	table_op_t     ops_todo[$];
	table_answer_t answers_due[$];
	int            ops_sent = 0;
	int            answers_seen = 0;
	int            err_cnt = 0;
	int            hold_at = -1;
	int            hold_left = 0;
	bit            hold_done = 1'b0;
	int            quiet_cycles = 0;

	// predicted table state
	logic [LEN_W-1:0]  len_tab [CHB_SYMBOLS];
	logic [CODE_W-1:0] code_tab [CHB_SYMBOLS];
	bit                codes_ok;
	status_t           build_st;

	// lengths as the stimulus leaves them, for clearing between rounds
	int gen_len [CHB_SYMBOLS];

	wire calm = (ops_sent >= CALM_LO) && (ops_sent < CALM_HI);

	canonical_huffman_code_builder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// canonical assignment over the whole length table
	function automatic status_t assign_codes();
		int unsigned     per_len [64];
		longint unsigned next_code [64];
		longint unsigned c;
		longint unsigned v;
		int              total;
		int              l;
		total = 0;
		c = 0;
		for (int b = 0; b < 64; b++) begin
			per_len[b] = 0;
			next_code[b] = 0;
		end
		for (int s = 0; s < CHB_SYMBOLS; s++) begin
			l = len_tab[s];
			if (l == 0) continue;
			if (l > CHB_MAX_CODE_LEN) return ST_OVER;
			per_len[l]++;
			total++;
		end
		if (total == 0) return ST_EMPTY;
		// c is the first code of length b before its own count is added
		for (int b = 1; b < 64; b++) begin
			v = c + per_len[b];
			if (v > (64'd1 << b)) return ST_OVER;
			next_code[b] = c;
			c = v << 1;
		end
		for (int s = 0; s < CHB_SYMBOLS; s++) begin
			l = len_tab[s];
			if (l == 0) continue;
			code_tab[s] = CODE_W'(next_code[l]);
			next_code[l]++;
		end
		return ST_OK;
	endfunction

	// apply one accepted word and return the answer it must produce
	function automatic table_answer_t table_answer(table_op_t op);
		table_answer_t a;
		a.code = '0;
		a.clen = '0;
		a.st = build_st;
		case (op.fn)
			FN_WRITE: begin
				len_tab[op.sym] = op.len;
				codes_ok = 1'b0;
				build_st = ST_NOT_BUILT;
				a.st = ST_NOT_BUILT;
			end
			FN_BUILD: begin
				build_st = assign_codes();
				codes_ok = (build_st == ST_OK);
				a.st = build_st;
			end
			FN_QUERY: begin
				if (codes_ok && len_tab[op.sym] != 0) begin
					a.code = code_tab[op.sym];
					a.clen = len_tab[op.sym];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [CODE_W-1:0] got,
		logic [CODE_W-1:0] want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch at answer %0d: %s got %h want %h", answers_seen, what, got, want);
	endtask

	task automatic add_op(func_t fn, int sym, int len, bit drain = 1'b0);
		table_op_t op;
		op.fn = fn;
		op.sym = SYM_W'(sym);
		op.len = LEN_W'(len);
		op.drain = drain;
		ops_todo.push_back(op);
		if (fn == FN_WRITE) gen_len[sym] = len;
	endtask

	// one round: pick a length set, clear old symbols, write, build, query
	task automatic random_round();
		int depths[$];
		int syms[$];
		bit taken [CHB_SYMBOLS];
		int splits;
		int pick;
		int d;
		int kind;
		int s;
		int j;
		int tmp;
		int nq;
		bit deep;
		depths = {0};
		deep = ($urandom_range(5) == 0);
		splits = deep ? CHB_MAX_CODE_LEN : $urandom_range(15, 1);
		// split leaves of a code tree; a deep round always splits the deepest
		for (int i = 0; i < splits; i++) begin
			pick = $urandom_range(depths.size() - 1);
			if (deep) begin
				for (int k = 0; k < depths.size(); k++)
					if (depths[k] > depths[pick]) pick = k;
			end
			d = depths[pick];
			if (d < CHB_MAX_CODE_LEN) begin
				depths[pick] = d + 1;
				depths.push_back(d + 1);
			end
		end
		kind = $urandom_range(99);
		if (kind >= 55 && kind < 70) begin
			// incomplete set
			tmp = $urandom_range(depths.size() - 1);
			for (int i = 0; i < tmp; i++)
				depths.delete($urandom_range(depths.size() - 1));
		end else if (kind >= 70 && kind < 82) begin
			// one leaf too many
			depths.push_back(depths[$urandom_range(depths.size() - 1)]);
		end else if (kind >= 82 && kind < 92) begin
			depths[$urandom_range(depths.size() - 1)] = $urandom_range(63, CHB_MAX_CODE_LEN + 1);
		end else if (kind >= 92) begin
			depths.delete();
		end
		foreach (depths[i]) begin
			do s = $urandom_range(CHB_SYMBOLS - 1); while (taken[s]);
			taken[s] = 1'b1;
			syms.push_back(s);
		end
		for (int i = syms.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = syms[i]; syms[i] = syms[j]; syms[j] = tmp;
			tmp = depths[i]; depths[i] = depths[j]; depths[j] = tmp;
		end

		if ($urandom_range(3) == 0) add_op(FN_NOP, $urandom_range(255), $urandom_range(63), 1'b1);
		for (int k = 0; k < CHB_SYMBOLS; k++)
			if (gen_len[k] != 0 && !taken[k]) add_op(FN_WRITE, k, 0);
		foreach (syms[i]) begin
			if ($urandom_range(9) == 0) add_op(FN_WRITE, syms[i], $urandom_range(63));
			add_op(FN_WRITE, syms[i], depths[i]);
			if ($urandom_range(7) == 0)
				add_op(func_t'($urandom_range(3) == 0 ? FN_NOP : FN_QUERY),
					$urandom_range(255), $urandom_range(63));
		end
		add_op(FN_BUILD, $urandom_range(255), $urandom_range(63));
		if ($urandom_range(4) == 0) add_op(FN_BUILD, 0, 0);
		nq = syms.size() + $urandom_range(4);
		for (int k = 0; k < nq; k++) begin
			s = (k < syms.size()) ? syms[k] : $urandom_range(255);
			add_op(FN_QUERY, s, $urandom_range(63));
		end
		if ($urandom_range(2) == 0) add_op(FN_NOP, $urandom_range(255), $urandom_range(63));
	endtask

	// input side: send queued words, predict each accepted one
	always @(posedge clk or negedge arst_n) begin : drive_ops
		table_op_t op;
		table_op_t done_op;
		bit took;
		bit idle;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= FN_NOP;
		end else begin
			took = s_axis_tvalid && s_axis_tready;
			if (took) begin
				done_op.fn = func_t'(s_axis_tuser);
				done_op.sym = s_axis_tdata[7:0];
				done_op.len = s_axis_tdata[13:8];
				done_op.drain = 1'b0;
				answers_due.push_back(table_answer(done_op));
				ops_sent <= ops_sent + 1;
			end
			if (!s_axis_tvalid || took) begin
				idle = !calm && ($urandom_range(99) < 24);
				if (ops_todo.size() != 0 && !idle
					&& !(ops_todo[0].drain && (took || ops_sent != answers_seen))) begin
					op = ops_todo.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, op.len, op.sym};
					s_axis_tuser <= op.fn;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random stalls, one long hold-off, in-order checking
	always @(posedge clk or negedge arst_n) begin : check_answers
		table_answer_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				answers_seen <= answers_seen + 1;
				if (answers_due.size() == 0) begin
					report_mismatch("word with no answer due", m_axis_tdata[31:0], '0);
				end else begin
					want = answers_due.pop_front();
					if (m_axis_tdata[31:0] !== want.code)
						report_mismatch("code", m_axis_tdata[31:0], want.code);
					if (m_axis_tdata[37:32] !== want.clen)
						report_mismatch("code_length", 32'(m_axis_tdata[37:32]), 32'(want.clen));
					if (m_axis_tuser !== want.st)
						report_mismatch("status", 32'(m_axis_tuser), 32'(want.st));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && hold_at >= 0 && ops_sent >= hold_at) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 24);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus list, reset and end of run
	initial begin : run_ops
		int base;
		for (int s = 0; s < CHB_SYMBOLS; s++) begin
			len_tab[s] = '0;
			code_tab[s] = '0;
			gen_len[s] = 0;
		end
		codes_ok = 1'b0;
		build_st = ST_NOT_BUILT;

		// directed corner cases
		add_op(FN_QUERY, 5, 0);              // nothing built yet
		add_op(FN_NOP, 0, 0);
		add_op(FN_BUILD, 0, 0);              // empty table
		add_op(FN_QUERY, 0, 0);
		add_op(FN_WRITE, 0, 1);
		add_op(FN_WRITE, 255, CHB_MAX_CODE_LEN);
		add_op(FN_WRITE, 128, 2);
		add_op(FN_BUILD, 0, 0);
		add_op(FN_QUERY, 0, 0);
		add_op(FN_QUERY, 255, 0);
		add_op(FN_QUERY, 128, 0);
		add_op(FN_QUERY, 7, 63);             // absent symbol
		add_op(FN_NOP, 255, 63);
		add_op(FN_WRITE, 1, 1);              // a second one-bit code leaves no room
		add_op(FN_BUILD, 0, 0);
		add_op(FN_QUERY, 0, 0);              // after a failed build
		add_op(FN_WRITE, 1, 0);
		add_op(FN_WRITE, 77, 63);            // length beyond the longest code
		add_op(FN_BUILD, 0, 0);
		add_op(FN_WRITE, 77, CHB_MAX_CODE_LEN + 1);
		add_op(FN_BUILD, 0, 0);
		add_op(FN_WRITE, 77, 0);
		add_op(FN_BUILD, 0, 0, 1'b1);
		add_op(FN_QUERY, 255, 0);
		add_op(FN_NOP, 0, 0);

		while (ops_todo.size() < 590) random_round();

		// full table of eight-bit codes, output held off early on
		hold_at = ops_todo.size() + 10;
		base = $urandom_range(255);
		for (int k = 0; k < CHB_SYMBOLS; k++) add_op(FN_WRITE, (base + k) % CHB_SYMBOLS, 8);
		add_op(FN_BUILD, 0, 0);
		for (int k = 0; k < 24; k++) add_op(FN_QUERY, $urandom_range(255), $urandom_range(63));
		add_op(FN_NOP, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_todo.size() != 0 || s_axis_tvalid || answers_seen < ops_sent)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (answers_due.size() != 0)
			report_mismatch("answers never returned", answers_due.size(), '0);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/chb_pkg.sv
sv/canonical_huffman_code_builder_top.sv
sv/chb_check.sv
tb/tb_top.sv
